### rtl/core/chx_pkg.sv
// chx_pkg: shared types, constants and helper functions for the chacha stream xor core
// depends on nothing
package chx_pkg;

   localparam int DOUBLE_ROUNDS_DEF = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int COUNT_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY01 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY23 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY45 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY67 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE = 3'd4;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646E;
   localparam logic [31:0] SIGMA2 = 32'h79622D32;
   localparam logic [31:0] SIGMA3 = 32'h6B206574;

   localparam logic [COUNT_W-1:0] FULL_COUNT = 7'd64;

   typedef logic [31:0] word_type;
   typedef word_type [15:0] state_type;

   typedef struct packed {
      logic        start_req;
      logic [63:0] data_0;
      logic [63:0] data_1;
      logic [63:0] data_2;
      logic [63:0] data_3;
      logic [63:0] data_4;
      logic [63:0] data_5;
      logic [63:0] data_6;
      logic [63:0] data_7;
      logic [6:0]  byte_count;
   } req_type;

   typedef struct packed {
      logic [63:0] out_0;
      logic [63:0] out_1;
      logic [63:0] out_2;
      logic [63:0] out_3;
      logic [63:0] out_4;
      logic [63:0] out_5;
      logic [63:0] out_6;
      logic [63:0] out_7;
      logic [6:0]  out_byte_count;
      logic        counter_error;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic          active;
      logic [63:0]   counter;
      logic [6:0]    count;
      logic          error;
      logic [511:0]  data;
   } job_type;

   typedef struct packed {
      logic [255:0] key;
      logic [63:0]  nonce;
   } cfg_type;

   function automatic word_type rotl(input word_type v, input int r);
      rotl = (v << r) | (v >> (32 - r));
   endfunction

   // one chacha quarter round on four words
   function automatic logic [127:0] qround(input word_type a_i, input word_type b_i,
                                          input word_type c_i, input word_type d_i);
      word_type a, b, c, d;
      a = a_i; b = b_i; c = c_i; d = d_i;
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      qround = {a, b, c, d};
   endfunction

endpackage

### rtl/core/chx_front.sv
// chx_front: accepts request beats, saturates the count and tracks counter and wrap flag
// depends on chx_pkg
module chx_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  chx_pkg::req_type req_data,
   input  logic            job_ready,
   output logic            full,
   output logic            job_valid,
   output chx_pkg::job_type job_data
);
   import chx_pkg::*;

   logic [63:0] counter_ff, counter_in;
   logic        error_ff, error_in;
   logic        accept;
   logic [63:0] ctr_now;
   logic        err_now;
   logic [6:0]  cnt;
   logic        act;
   logic [63:0] ctr_inc;

   assign full      = !job_ready;
   assign accept    = push && job_ready;
   assign job_valid = push;

   // classify the beat against current counter state
   always_comb begin
      ctr_now = req_data.start_req ? 64'd0 : counter_ff;
      err_now = req_data.start_req ? 1'b0 : error_ff;
      cnt     = (req_data.byte_count > FULL_COUNT) ? FULL_COUNT : req_data.byte_count;
      act     = (cnt != 7'd0) && !err_now;
      ctr_inc = ctr_now + 64'd1;
      counter_in = ctr_now;
      error_in   = err_now;
      if (act && cnt == FULL_COUNT) begin
         counter_in = ctr_inc;
         if (ctr_inc == 64'd0) begin
            error_in = 1'b1;
         end
      end
      job_data.active  = act;
      job_data.counter = ctr_now;
      job_data.count   = cnt;
      job_data.error   = error_in;
      job_data.data    = {req_data.data_7, req_data.data_6, req_data.data_5, req_data.data_4,
                          req_data.data_3, req_data.data_2, req_data.data_1, req_data.data_0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         error_ff   <= 1'b0;
      end else if (accept) begin
         counter_ff <= counter_in;
         error_ff   <= error_in;
      end
   end

endmodule

### rtl/core/chx_queue.sv
// chx_queue: two-entry job queue between front and back
// depends on chx_pkg
module chx_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  chx_pkg::job_type in_data,
   output logic            in_ready,
   output logic            out_valid,
   output chx_pkg::job_type out_data,
   input  logic            out_ready
);
   import chx_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] fill_ff;
   logic       do_wr, do_rd;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rd_ff];
   assign do_wr     = in_valid && in_ready;
   assign do_rd     = out_valid && out_ready;

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ff] <= in_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (do_wr) wr_ff <= !wr_ff;
         if (do_rd) rd_ff <= !rd_ff;
         fill_ff <= fill_ff + {1'b0, do_wr} - {1'b0, do_rd};
      end
   end

endmodule

### rtl/core/chx_back.sv
// chx_back: runs chacha rounds one per cycle with four quarter-round lanes, xors and masks
// depends on chx_pkg
module chx_back #(
   parameter int DOUBLE_ROUNDS = chx_pkg::DOUBLE_ROUNDS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  chx_pkg::cfg_type cfg,
   input  logic            job_valid,
   input  chx_pkg::job_type job_data,
   output logic            job_ready,
   output logic            rsp_valid,
   output chx_pkg::rsp_type rsp_data,
   input  logic            rsp_ready
);
   import chx_pkg::*;

   localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
   localparam int RND_W  = $clog2(ROUNDS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_e_type;

   state_e_type     state_ff, state_in;
   logic [RND_W-1:0] round_ff, round_in;
   state_type       work_ff, work_in;
   state_type       init_ff, init_in;
   job_type         job_ff, job_in;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_ff, out_in;
   state_type       init_now;
   state_type       rnd;
   logic            take;
   logic            out_free;
   logic [511:0]    ks;
   logic [511:0]    mask;
   logic [511:0]    word;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign job_ready = (state_ff == ST_IDLE) ||
                      (state_ff == ST_FIN && out_free);
   assign take      = job_valid && job_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // initial state words
   always_comb begin
      init_now[0]  = SIGMA0;
      init_now[1]  = SIGMA1;
      init_now[2]  = SIGMA2;
      init_now[3]  = SIGMA3;
      for (int i = 0; i < 8; i++) begin
         init_now[4 + i] = cfg.key[32*i +: 32];
      end
      init_now[12] = job_data.counter[31:0];
      init_now[13] = job_data.counter[63:32];
      init_now[14] = cfg.nonce[31:0];
      init_now[15] = cfg.nonce[63:32];
   end

   // one round: column on even steps, diagonal on odd steps
   always_comb begin
      rnd = work_ff;
      if (!round_ff[0]) begin
         for (int l = 0; l < 4; l++) begin
            {rnd[l], rnd[4+l], rnd[8+l], rnd[12+l]} =
               qround(work_ff[l], work_ff[4+l], work_ff[8+l], work_ff[12+l]);
         end
      end else begin
         for (int l = 0; l < 4; l++) begin
            {rnd[l], rnd[4+((l+1)%4)], rnd[8+((l+2)%4)], rnd[12+((l+3)%4)]} =
               qround(work_ff[l], work_ff[4+((l+1)%4)], work_ff[8+((l+2)%4)],
                      work_ff[12+((l+3)%4)]);
         end
      end
   end

   // feed-forward, xor and byte mask
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         ks[32*i +: 32] = work_ff[i] + init_ff[i];
      end
      for (int b = 0; b < 64; b++) begin
         mask[8*b +: 8] = (7'(b) < job_ff.count) ? 8'hFF : 8'h00;
      end
      word = job_ff.active ? ((job_ff.data ^ ks) & mask) : '0;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      work_in      = work_ff;
      init_in      = init_ff;
      job_in       = job_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      case (state_ff)
         ST_IDLE: begin
         end
         ST_RUN: begin
            work_in  = rnd;
            round_in = round_ff + RND_W'(1);
            if (round_ff == RND_W'(ROUNDS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = {word[63:0], word[127:64], word[191:128], word[255:192],
                         word[319:256], word[383:320], word[447:384], word[511:448],
                         job_ff.count, job_ff.error};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (take) begin
         state_in = ST_RUN;
         round_in = '0;
         work_in  = init_now;
         init_in  = init_now;
         job_in   = job_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      round_ff <= round_in;
      work_ff  <= work_in;
      init_ff  <= init_in;
      job_ff   <= job_in;
      out_ff   <= out_in;
   end

endmodule

### rtl/core/chacha8_stream_xor_core.sv
// chacha8 stream xor core: a result passes through the queue, the round sequencer (8 rounds,
// one per cycle) and the output register; the back end works on one 64-byte block at a time
// and takes the next one in its finish state once the output register is free.
// synchronous active-high reset clears counter, wrap flag, key and nonce registers
// and empties queue and output; depends on chx_pkg and chx_front, chx_queue, chx_back
module chacha8_stream_xor_core #(
   parameter int DOUBLE_ROUNDS = chx_pkg::DOUBLE_ROUNDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  chx_pkg::req_type                  req_data,
   output logic                              empty,
   input  logic                              pop,
   output chx_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [chx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [chx_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import chx_pkg::*;

   cfg_type cfg_ff;
   logic    q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   job_type q_in_data, q_out_data;
   logic    rsp_valid;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY01: cfg_ff.key[63:0]    <= csr_wdata;
            CSR_KEY23: cfg_ff.key[127:64]  <= csr_wdata;
            CSR_KEY45: cfg_ff.key[191:128] <= csr_wdata;
            CSR_KEY67: cfg_ff.key[255:192] <= csr_wdata;
            CSR_NONCE: cfg_ff.nonce        <= csr_wdata;
            default: ;
         endcase
      end
   end

   chx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .job_ready (q_in_ready),
      .full      (full),
      .job_valid (q_in_valid),
      .job_data  (q_in_data)
   );

   chx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_data   (q_in_data),
      .in_ready  (q_in_ready),
      .out_valid (q_out_valid),
      .out_data  (q_out_data),
      .out_ready (q_out_ready)
   );

   chx_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (q_out_valid),
      .job_data  (q_out_data),
      .job_ready (q_out_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (pop)
   );

   assign empty = !rsp_valid;

endmodule

### tb/sv/chx_checker.sv
// chx_checker: watches the request and result queues of the chacha stream xor core,
// predicts each result from its own cipher model and compares field by field
// depends on chx_pkg
`timescale 1ns / 1ps
module chx_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           full,
   input  chx_pkg::req_type               req_data,
   input  logic                           empty,
   input  logic                           pop,
   input  chx_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [chx_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [chx_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending
);
   import chx_pkg::*;

   logic [63:0] key_reg [4];
   logic [63:0] nonce_reg;
   logic [63:0] blk_ctr;
   logic        wrapped;
   rsp_type     cipher_q [$];

   function automatic logic [31:0] rol32(logic [31:0] v, int r);
      return (v << r) | (v >> (32 - r));
   endfunction

   function automatic void mix(ref logic [31:0] w [16], input int a, int b, int c, int d);
      w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 16);
      w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 12);
      w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 8);
      w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 7);
   endfunction

   // keystream block for one counter value
   function automatic void keystream(input logic [63:0] ctr, output logic [31:0] ks [16]);
      logic [31:0] init [16];
      init[0] = 32'h61707865; init[1] = 32'h3320646E;
      init[2] = 32'h79622D32; init[3] = 32'h6B206574;
      for (int i = 0; i < 4; i++) begin
         init[4 + 2 * i] = key_reg[i][31:0];
         init[5 + 2 * i] = key_reg[i][63:32];
      end
      init[12] = ctr[31:0];    init[13] = ctr[63:32];
      init[14] = nonce_reg[31:0]; init[15] = nonce_reg[63:32];
      ks = init;
      for (int r = 0; r < 4; r++) begin
         mix(ks, 0, 4, 8, 12); mix(ks, 1, 5, 9, 13);
         mix(ks, 2, 6, 10, 14); mix(ks, 3, 7, 11, 15);
         mix(ks, 0, 5, 10, 15); mix(ks, 1, 6, 11, 12);
         mix(ks, 2, 7, 8, 13); mix(ks, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks[i] += init[i];
   endfunction

   // encrypt one beat and advance the counter state
   function automatic rsp_type encrypt_block(req_type rq);
      rsp_type     rs;
      logic [31:0] ks [16];
      logic [63:0] din [8];
      logic [63:0] w;
      int          cnt, lo;
      logic        act;
      if (rq.start_req) begin
         blk_ctr = '0;
         wrapped = 1'b0;
      end
      cnt = rq.byte_count;
      if (cnt > 64) cnt = 64;
      act = (cnt != 0) && !wrapped;
      din = '{rq.data_0, rq.data_1, rq.data_2, rq.data_3,
              rq.data_4, rq.data_5, rq.data_6, rq.data_7};
      for (int i = 0; i < 16; i++) ks[i] = '0;
      if (act) keystream(blk_ctr, ks);
      for (int j = 0; j < 8; j++) begin
         lo = 8 * j;
         w = '0;
         if (act) begin
            w = din[j] ^ {ks[2 * j + 1], ks[2 * j]};
            if (cnt <= lo) w = '0;
            else if (cnt < lo + 8) w &= (64'd1 << (8 * (cnt - lo))) - 64'd1;
         end
         case (j)
            0: rs.out_0 = w; 1: rs.out_1 = w; 2: rs.out_2 = w; 3: rs.out_3 = w;
            4: rs.out_4 = w; 5: rs.out_5 = w; 6: rs.out_6 = w; default: rs.out_7 = w;
         endcase
      end
      if (act && cnt == 64) begin
         blk_ctr = blk_ctr + 64'd1;
         if (blk_ctr == 0) wrapped = 1'b1;
      end
      rs.out_byte_count = cnt[6:0];
      rs.counter_error = wrapped;
      return rs;
   endfunction

   task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < 4; i++) key_reg[i] = '0;
         nonce_reg = '0;
         blk_ctr = '0;
         wrapped = 1'b0;
         cipher_q.delete();
      end else begin
         // config write
         if (csr_we) begin
            case (csr_index)
               CSR_KEY01: key_reg[0] = csr_wdata;
               CSR_KEY23: key_reg[1] = csr_wdata;
               CSR_KEY45: key_reg[2] = csr_wdata;
               CSR_KEY67: key_reg[3] = csr_wdata;
               CSR_NONCE: nonce_reg = csr_wdata;
               default: ;
            endcase
         end
         // result beat
         if (pop && !empty) begin
            if (cipher_q.size() == 0) begin
               $error("unexpected result beat");
               fail_count++;
            end else begin
               e = cipher_q.pop_front();
               cmp("out_0", e.out_0, rsp_data.out_0);
               cmp("out_1", e.out_1, rsp_data.out_1);
               cmp("out_2", e.out_2, rsp_data.out_2);
               cmp("out_3", e.out_3, rsp_data.out_3);
               cmp("out_4", e.out_4, rsp_data.out_4);
               cmp("out_5", e.out_5, rsp_data.out_5);
               cmp("out_6", e.out_6, rsp_data.out_6);
               cmp("out_7", e.out_7, rsp_data.out_7);
               cmp("out_byte_count", e.out_byte_count, rsp_data.out_byte_count);
               cmp("counter_error", e.counter_error, rsp_data.counter_error);
            end
         end
         // request beat
         if (push && !full) cipher_q.push_back(encrypt_block(req_data));
      end
      pending = cipher_q.size();
   end
endmodule

### tb/sv/testbench.sv
// testbench: drives request beats and config writes into chacha8_stream_xor_core
// and gives the verdict; depends on chx_pkg, chx_checker and chacha8_stream_xor_core
`timescale 1ns / 1ps
module testbench;
   import chx_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   req_type               req_data;
   logic                  empty;
   logic                  pop;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;
   int                    stall_mode;

   chacha8_stream_xor_core dut (.*);

   chx_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // receiver stall pattern, mode changes per phase
   always @(negedge clock) begin
      if (reset) pop <= 1'b0;
      else case (stall_mode)
         0: pop <= 1'b1;
         1: pop <= ($urandom_range(0, 3) != 0);
         2: pop <= ($urandom_range(0, 3) == 0);
         default: pop <= ($urandom_range(0, 30) == 0);
      endcase
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until all results have been drained
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic load_key(logic [63:0] k0, k1, k2, k3, n);
      write_reg(CSR_KEY01, k0); write_reg(CSR_KEY23, k1);
      write_reg(CSR_KEY45, k2); write_reg(CSR_KEY67, k3);
      write_reg(CSR_NONCE, n);
   endtask

   // one request beat; caller is at a falling edge
   task automatic send_block(logic st, logic [6:0] cnt, logic [511:0] d);
      req_data <= {st, d, cnt};
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [511:0] rand_data();
      return {rand64(), rand64(), rand64(), rand64(),
              rand64(), rand64(), rand64(), rand64()};
   endfunction

   function automatic logic [6:0] rand_count();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 7'd64;
      if (r < 17) return 7'($urandom_range(1, 63));
      if (r == 17) return 7'd0;
      return 7'($urandom_range(65, 127));
   endfunction

   task automatic random_phase(int n);
      int left, burst;
      logic st;
      left = n;
      st = 1'b1;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && left > 0) begin
            send_block(st, rand_count(), rand_data());
            st = ($urandom_range(0, 15) == 0);
            burst--; left--;
         end
         if ($urandom_range(0, 2) != 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge clock);
         end
      end
      push <= 1'b0;
   endtask

   initial begin
      push = 1'b0; req_data = '0;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      stall_mode = 0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset key, extremes of counts and data
      send_block(1'b1, 7'd64, '0);
      send_block(1'b0, 7'd64, '1);
      send_block(1'b0, 7'd1, '1);
      send_block(1'b1, 7'd63, '1);
      send_block(1'b1, 7'd0, '1);
      send_block(1'b0, 7'd127, rand_data());
      send_block(1'b0, 7'd65, rand_data());
      send_block(1'b1, 7'd8, rand_data());
      send_block(1'b1, 7'd9, rand_data());
      push <= 1'b0;
      drain();

      // all-ones key and nonce
      load_key('1, '1, '1, '1, '1);
      send_block(1'b1, 7'd64, '0);
      send_block(1'b0, 7'd64, rand_data());
      send_block(1'b0, 7'd33, rand_data());
      push <= 1'b0;
      drain();

      // counter wrap: a counter of 2^64-1 is out of reach, so the wrap case and its sticky
      // flag are not reached here; run long mostly full-block streams under each stall mode
      // to exercise counter carries instead
      for (int ph = 0; ph < 6; ph++) begin
         stall_mode = ph % 4;
         load_key(rand64(), rand64(), rand64(), rand64(),
                  (ph == 1) ? 64'd0 : rand64());
         random_phase(225);
         drain();
      end

      stall_mode = 0;
      drain();
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
